FILE: hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, constants and helper functions of the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int CLIENTS      = 16;
	localparam int LENGTH_BITS  = 64;
	localparam int CLIENT_W     = 4;
	localparam int SLOT_W       = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] FIN_BIT     = 8'h80;
	localparam logic [7:0] MASK_BIT    = 8'h80;
	localparam logic [3:0] OPCODE_MASK = 4'hF;
	localparam logic [6:0] LEN7_MASK   = 7'h7F;
	localparam logic [6:0] LEN7_EXT16  = 7'd126;
	localparam logic [6:0] LEN7_EXT64  = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	typedef enum logic [2:0] {
		KIND_DATA   = 3'd0,
		KIND_CLOSE  = 3'd1,
		KIND_PING   = 3'd2,
		KIND_PONG   = 3'd3,
		KIND_IGNORE = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CLOSED  = 3'd5
	} phase_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_OPEN = 1'b1
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t              op;
		logic [CLIENT_W-1:0]  client;
		logic [7:0]           data;
	} cmd_t;

	typedef struct packed {
		phase_t                  phase;
		logic                    fin;
		logic [3:0]              opcode;
		logic                    masked;
		logic                    sat;
		logic [LENGTH_BITS-1:0]  left;
		logic [3:0]              hbc;
		logic [31:0]             mask;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{
		phase:  PH_HDR0,
		fin:    1'b0,
		opcode: 4'd0,
		masked: 1'b0,
		sat:    1'b0,
		left:   {LENGTH_BITS{1'b0}},
		hbc:    4'd0,
		mask:   32'd0
	};

	typedef struct packed {
		logic [CLIENT_W-1:0]  client;
		logic [7:0]           payload;
		logic                 valid;
		logic [3:0]           opcode;
		logic                 fin;
		kind_t                kind;
		logic                 last;
	} result_t;

	function automatic kind_t kind_of(input logic [3:0] opcode);
		kind_t k;
		unique case (opcode)
			OP_CONT, OP_TEXT, OP_BIN: k = KIND_DATA;
			OP_CLOSE:                 k = KIND_CLOSE;
			OP_PING:                  k = KIND_PING;
			OP_PONG:                  k = KIND_PONG;
			default:                  k = KIND_IGNORE;
		endcase
		return k;
	endfunction

endpackage

FILE: hdl/wsd_front.sv
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Accepts items, drops those for slots out of range, and classifies the rest
// as received bytes or open commands before handing them to the queue.
// ----------------------------------------------------------------------------
module wsd_front import wsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 action,
	input  logic [CLIENT_W-1:0]  client,
	input  logic [7:0]           rx_byte,
	output logic                 q_push,
	output cmd_t                 q_cmd,
	input  logic                 q_full
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic advance;
	logic load;
	logic in_range;

	assign advance  = valid_s1 && !q_full;
	assign load     = !valid_s1 || advance;
	assign full     = !load;
	assign in_range = int'(client) < CLIENTS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= push && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (load && push) begin
			cmd_s1.op     <= action ? CMD_OPEN : CMD_BYTE;
			cmd_s1.client <= client;
			cmd_s1.data   <= rx_byte;
		end
	end

	assign q_push = advance;
	assign q_cmd  = cmd_s1;

endmodule

FILE: hdl/wsd_cmd_queue.sv
// ----------------------------------------------------------------------------
// WebSocket deframer command queue
// Short first-in first-out queue that decouples the front end from the
// context engine.
// ----------------------------------------------------------------------------
module wsd_cmd_queue import wsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_cmd,
	output logic  full,
	input  logic  pop,
	output cmd_t  head_cmd,
	output logic  empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: hdl/wsd_back.sv
// ----------------------------------------------------------------------------
// WebSocket deframer context engine
// Holds the parsing context of every slot, decodes frame headers, unmasks
// payload bytes and buffers results for the receiver.
// ----------------------------------------------------------------------------
module wsd_back import wsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_t     cmd,
	input  logic     cmd_empty,
	output logic     cmd_pop,
	output result_t  res,
	output logic     empty,
	input  logic     pop
);

	localparam int LEN_W = LENGTH_BITS;

	ctx_t              ctx_q [CLIENTS];
	result_t           res_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	logic [SLOT_W-1:0] slot;
	ctx_t              cur;
	ctx_t              nxt;
	logic              take;
	logic              emit;
	logic [7:0]        res_byte;
	logic              res_valid;
	logic              res_last;
	logic              len_done;
	logic              start;
	logic              end_frame;
	logic [6:0]        len7;
	logic [1:0]        pos;
	logic [31:0]       key_word;
	logic              do_pop;
	result_t           new_res;

	assign slot    = SLOT_W'(cmd.client);
	assign take    = !cmd_empty && (count_q != 2'd2);
	assign cmd_pop = take;
	assign len7    = cmd.data[6:0] & LEN7_MASK;

	always_comb begin
		cur       = ctx_q[slot];
		nxt       = cur;
		emit      = 1'b0;
		res_byte  = 8'd0;
		res_valid = 1'b0;
		res_last  = 1'b0;
		len_done  = 1'b0;
		start     = 1'b0;
		end_frame = 1'b0;
		pos       = cur.hbc[1:0];
		key_word  = cur.mask >> {~pos, 3'b000};
		if (cmd.op == CMD_OPEN) begin
			nxt = CTX_RESET;
		end else begin
			unique case (cur.phase)
				PH_CLOSED: begin
				end
				PH_HDR1: begin
					nxt.masked = (cmd.data & MASK_BIT) != 8'd0;
					nxt.left   = '0;
					nxt.sat    = 1'b0;
					if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
						nxt.phase = PH_EXTLEN;
						nxt.hbc   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					end else begin
						nxt.left = LEN_W'(len7);
						len_done = 1'b1;
					end
				end
				PH_EXTLEN: begin
					nxt.left = {cur.left[LEN_W-9:0], cmd.data};
					nxt.sat  = cur.sat || (cur.left[LEN_W-1 -: 8] != 8'd0);
					nxt.hbc  = cur.hbc - 4'd1;
					len_done = nxt.hbc == 4'd0;
				end
				PH_MASK: begin
					nxt.mask = {cur.mask[23:0], cmd.data};
					nxt.hbc  = cur.hbc - 4'd1;
					start    = nxt.hbc == 4'd0;
				end
				PH_PAYLOAD: begin
					nxt.hbc   = {2'b00, pos + 2'd1};
					nxt.left  = cur.left - 1'b1;
					emit      = 1'b1;
					res_byte  = cmd.data ^ key_word[7:0];
					res_valid = 1'b1;
					res_last  = nxt.left == '0;
					end_frame = res_last;
				end
				default: begin
					nxt.fin    = (cmd.data & FIN_BIT) != 8'd0;
					nxt.opcode = cmd.data[3:0] & OPCODE_MASK;
					nxt.masked = 1'b0;
					nxt.sat    = 1'b0;
					nxt.left   = '0;
					nxt.hbc    = 4'd0;
					nxt.mask   = 32'd0;
					nxt.phase  = PH_HDR1;
				end
			endcase
			if (len_done) begin
				if (nxt.sat) begin
					nxt.left = '1;
				end
				nxt.sat  = 1'b0;
				nxt.mask = 32'd0;
				if (nxt.masked) begin
					nxt.phase = PH_MASK;
					nxt.hbc   = KEY_BYTES;
				end else begin
					start = 1'b1;
				end
			end
			if (start) begin
				nxt.hbc = 4'd0;
				if (nxt.left == '0) begin
					emit      = 1'b1;
					res_last  = 1'b1;
					end_frame = 1'b1;
				end else begin
					nxt.phase = PH_PAYLOAD;
				end
			end
			if (end_frame) begin
				nxt.phase = (nxt.opcode == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
				nxt.hbc   = 4'd0;
			end
		end
		new_res.client  = cmd.client;
		new_res.payload = res_byte;
		new_res.valid   = res_valid;
		new_res.opcode  = nxt.opcode;
		new_res.fin     = nxt.fin;
		new_res.kind    = kind_of(nxt.opcode);
		new_res.last    = res_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLIENTS; i++) begin
				ctx_q[i] <= CTX_RESET;
			end
		end else if (take) begin
			ctx_q[slot] <= nxt;
		end
	end

	assign do_pop = pop && (count_q != 2'd0);
	assign empty  = count_q == 2'd0;
	assign res    = res_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (take && emit) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (take && emit && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !(take && emit)) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q[wr_ptr_q] <= new_res;
		end
	end

endmodule

FILE: hdl/websocket_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// Parses framed byte streams of up to CLIENTS connections into unmasked
// payload bytes tagged with frame opcode, fin bit, kind and end of frame.
//
// Input side: an item (action, client, rx_byte) is taken on a clock edge with
// push high and full low. Action open resets the connection's parsing context
// and yields no result; header bytes and bytes of a closed connection yield
// none either. Each payload byte yields one result, and a frame with an empty
// payload yields one marker result with byte_valid low.
// Output side: the oldest result is shown while empty is low and leaves on a
// clock edge with pop high.
// An item passes the input stage register and the command queue before the
// context engine writes its result into the result buffer.
// Throughput is one item per cycle while the result buffer has room, set by the single read-modify-write of the
// per-connection context in the context engine.
// Reset clears every connection's context and empties all queues. When pop
// stays low, the two-entry result buffer, the four-entry command queue and the
// input stage fill in turn, and full then rises.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core import wsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 action,
	input  logic [CLIENT_W-1:0]  client,
	input  logic [7:0]           rx_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic [CLIENT_W-1:0]  client_out,
	output logic [7:0]           payload_byte,
	output logic                 byte_valid,
	output logic [3:0]           frame_opcode,
	output logic                 frame_fin,
	output logic [2:0]           frame_kind,
	output logic                 last_of_frame
);

	logic    q_push;
	cmd_t    q_in;
	logic    q_full;
	logic    q_pop;
	cmd_t    q_head;
	logic    q_empty;
	result_t res;

	wsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.action  (action),
		.client  (client),
		.rx_byte (rx_byte),
		.q_push  (q_push),
		.q_cmd   (q_in),
		.q_full  (q_full)
	);

	wsd_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (q_head),
		.empty    (q_empty)
	);

	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_head),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.res       (res),
		.empty     (empty),
		.pop       (pop)
	);

	assign client_out    = res.client;
	assign payload_byte  = res.payload;
	assign byte_valid    = res.valid;
	assign frame_opcode  = res.opcode;
	assign frame_fin     = res.fin;
	assign frame_kind    = res.kind;
	assign last_of_frame = res.last;

endmodule

FILE: hdl/wsd_checker.sv
// ----------------------------------------------------------------------------
// WebSocket deframer checker
// Concurrent assertions on the ports of the deframer core.
// ----------------------------------------------------------------------------
module wsd_checker import wsd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic                 action,
	input  logic [CLIENT_W-1:0]  client,
	input  logic [7:0]           rx_byte,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [CLIENT_W-1:0]  client_out,
	input  logic [7:0]           payload_byte,
	input  logic                 byte_valid,
	input  logic [3:0]           frame_opcode,
	input  logic                 frame_fin,
	input  logic [2:0]           frame_kind,
	input  logic                 last_of_frame
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(payload_byte) && $stable(client_out)))
		else $error("Waiting item changed before it was taken.");

	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> (last_of_frame && payload_byte == 8'd0))
		else $error("Empty-frame marker is malformed.");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_opcode == OP_CLOSE) |-> (frame_kind == KIND_CLOSE))
		else $error("Close opcode carries the wrong kind.");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_kind == KIND_DATA) |->
		(frame_opcode == OP_CONT || frame_opcode == OP_TEXT || frame_opcode == OP_BIN))
		else $error("Data kind on a non-data opcode.");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);

FILE: bench/tb_websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the WebSocket frame deframer core
// Drives byte and open items for all sixteen connections and keeps a
// per-connection copy of the frame parser to predict every result. The result
// queue of the block is drained with random stalls and one long hold-off, and
// each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_core;
	import wsd_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int FRAME_MAX    = 320;

	typedef enum logic [1:0] {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_form_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	logic                action = 1'b0;
	logic [CLIENT_W-1:0] client = '0;
	logic [7:0]          rx_byte = 8'h00;
	logic                empty;
	logic                pop = 1'b0;
	logic [CLIENT_W-1:0] client_out;
	logic [7:0]          payload_byte;
	logic                byte_valid;
	logic [3:0]          frame_opcode;
	logic                frame_fin;
	logic [2:0]          frame_kind;
	logic                last_of_frame;

	phase_t      ctx_phase  [CLIENTS];
	logic        ctx_fin    [CLIENTS];
	logic [3:0]  ctx_opcode [CLIENTS];
	logic        ctx_masked [CLIENTS];
	logic [63:0] ctx_left   [CLIENTS];
	logic [3:0]  ctx_hbc    [CLIENTS];
	logic [31:0] ctx_key    [CLIENTS];

	result_t expected_results[$];

	logic [7:0] frame_buf [CLIENTS][FRAME_MAX];
	int         frame_len [CLIENTS];
	int         frame_pos [CLIENTS];

	int failures = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	websocket_frame_deframer_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.client        (client),
		.rx_byte       (rx_byte),
		.empty         (empty),
		.pop           (pop),
		.client_out    (client_out),
		.payload_byte  (payload_byte),
		.byte_valid    (byte_valid),
		.frame_opcode  (frame_opcode),
		.frame_fin     (frame_fin),
		.frame_kind    (frame_kind),
		.last_of_frame (last_of_frame)
	);

	always #5 clk = ~clk;

	function automatic kind_t opcode_kind(logic [3:0] op);
		case (op)
			OP_CONT, OP_TEXT, OP_BIN: return KIND_DATA;
			OP_CLOSE:                 return KIND_CLOSE;
			OP_PING:                  return KIND_PING;
			OP_PONG:                  return KIND_PONG;
			default:                  return KIND_IGNORE;
		endcase
	endfunction

	function automatic void clear_context(logic [3:0] cl);
		ctx_phase[cl]  = PH_HDR0;
		ctx_fin[cl]    = 1'b0;
		ctx_opcode[cl] = 4'h0;
		ctx_masked[cl] = 1'b0;
		ctx_left[cl]   = 64'd0;
		ctx_hbc[cl]    = 4'd0;
		ctx_key[cl]    = 32'd0;
	endfunction

	function automatic void expect_result(logic [3:0] cl, logic [7:0] data, logic valid,
			logic last);
		result_t r;
		r.client  = cl;
		r.payload = data;
		r.valid   = valid;
		r.opcode  = ctx_opcode[cl];
		r.fin     = ctx_fin[cl];
		r.kind    = opcode_kind(ctx_opcode[cl]);
		r.last    = last;
		expected_results.push_back(r);
	endfunction

	function automatic void close_frame(logic [3:0] cl);
		ctx_phase[cl] = (ctx_opcode[cl] == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
		ctx_hbc[cl]   = 4'd0;
	endfunction

	function automatic void begin_payload(logic [3:0] cl);
		ctx_hbc[cl] = 4'd0;
		if (ctx_left[cl] == 64'd0) begin
			expect_result(cl, 8'h00, 1'b0, 1'b1);
			close_frame(cl);
		end else begin
			ctx_phase[cl] = PH_PAYLOAD;
		end
	endfunction

	function automatic void length_complete(logic [3:0] cl);
		logic [63:0] limit;
		limit = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_BITS);
		if (ctx_left[cl] > limit)
			ctx_left[cl] = limit;
		ctx_key[cl] = 32'd0;
		if (ctx_masked[cl]) begin
			ctx_phase[cl] = PH_MASK;
			ctx_hbc[cl]   = KEY_BYTES;
		end else begin
			begin_payload(cl);
		end
	endfunction

	function automatic void predict_item(cmd_op_t act, logic [3:0] cl, logic [7:0] b);
		logic [1:0] pos;
		logic [7:0] key_byte;
		if (int'(cl) >= CLIENTS)
			return;
		if (act == CMD_OPEN) begin
			clear_context(cl);
			return;
		end
		case (ctx_phase[cl])
			PH_CLOSED: ;
			PH_HDR1: begin
				ctx_masked[cl] = b[7];
				ctx_left[cl]   = 64'd0;
				if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
					ctx_phase[cl] = PH_EXTLEN;
					ctx_hbc[cl]   = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
				end else begin
					ctx_left[cl] = {57'd0, b[6:0]};
					length_complete(cl);
				end
			end
			PH_EXTLEN: begin
				ctx_left[cl] = {ctx_left[cl][55:0], b};
				ctx_hbc[cl]  = ctx_hbc[cl] - 4'd1;
				if (ctx_hbc[cl] == 4'd0)
					length_complete(cl);
			end
			PH_MASK: begin
				ctx_key[cl] = {ctx_key[cl][23:0], b};
				ctx_hbc[cl] = ctx_hbc[cl] - 4'd1;
				if (ctx_hbc[cl] == 4'd0)
					begin_payload(cl);
			end
			PH_PAYLOAD: begin
				pos          = ctx_hbc[cl][1:0];
				key_byte     = ctx_key[cl][8 * (3 - pos) +: 8];
				ctx_hbc[cl]  = {2'b00, pos + 2'd1};
				ctx_left[cl] = ctx_left[cl] - 64'd1;
				expect_result(cl, b ^ key_byte, 1'b1, ctx_left[cl] == 64'd0);
				if (ctx_left[cl] == 64'd0)
					close_frame(cl);
			end
			default: begin
				clear_context(cl);
				ctx_fin[cl]    = b[7];
				ctx_opcode[cl] = b[3:0];
				ctx_phase[cl]  = PH_HDR1;
			end
		endcase
	endfunction

	function automatic void compose_frame(logic [3:0] cl, logic fin, logic [3:0] op,
			logic masked, len_form_t form, logic [63:0] len, logic [31:0] key, int nbytes);
		int n;
		n = 0;
		frame_buf[cl][n] = {fin, 3'($urandom), op};
		n++;
		case (form)
			LEN_SHORT: begin
				frame_buf[cl][n] = {masked, len[6:0]};
				n++;
			end
			LEN_EXT16: begin
				frame_buf[cl][n] = {masked, LEN7_EXT16};
				n++;
				for (int i = 1; i >= 0; i--) begin
					frame_buf[cl][n] = len[8 * i +: 8];
					n++;
				end
			end
			default: begin
				frame_buf[cl][n] = {masked, LEN7_EXT64};
				n++;
				for (int i = 7; i >= 0; i--) begin
					frame_buf[cl][n] = len[8 * i +: 8];
					n++;
				end
			end
		endcase
		if (masked) begin
			for (int i = 3; i >= 0; i--) begin
				frame_buf[cl][n] = key[8 * i +: 8];
				n++;
			end
		end
		for (int i = 0; i < nbytes; i++) begin
			frame_buf[cl][n] = 8'($urandom);
			n++;
		end
		frame_len[cl] = n;
		frame_pos[cl] = 0;
	endfunction

	// Entered and left at a falling edge; push stays high on return until the
	// next call or wait_drained takes it over in the same time step.
	task automatic send_item(cmd_op_t act, logic [3:0] cl, logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push    <= 1'b1;
		action  <= act;
		client  <= cl;
		rx_byte <= b;
		do
			@(posedge clk);
		while (full);
		predict_item(act, cl, b);
		@(negedge clk);
	endtask

	task automatic play_frame(logic [3:0] cl);
		while (frame_pos[cl] < frame_len[cl]) begin
			send_item(CMD_BYTE, cl, frame_buf[cl][frame_pos[cl]]);
			frame_pos[cl]++;
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic test_masked_text();
		send_item(CMD_OPEN, 4'd0, 8'h00);
		compose_frame(4'd0, 1'b1, OP_TEXT, 1'b1, LEN_SHORT, 64'd2, 32'hFF00_A55A, 2);
		play_frame(4'd0);
		wait_drained();
	endtask

	task automatic test_ext64_ignored_opcode();
		compose_frame(4'd3, 1'b1, 4'h3, 1'b0, LEN_EXT64, 64'd1, 32'd0, 1);
		play_frame(4'd3);
		wait_drained();
	endtask

	task automatic test_empty_ping();
		compose_frame(4'd15, 1'b0, OP_PING, 1'b0, LEN_SHORT, 64'd0, 32'd0, 0);
		play_frame(4'd15);
		wait_drained();
	endtask

	task automatic test_close_and_reopen();
		compose_frame(4'd5, 1'b1, OP_CLOSE, 1'b0, LEN_SHORT, 64'd0, 32'd0, 0);
		play_frame(4'd5);
		send_item(CMD_BYTE, 4'd5, 8'hFF);
		send_item(CMD_OPEN, 4'd5, 8'hFF);
		compose_frame(4'd5, 1'b1, OP_TEXT, 1'b0, LEN_SHORT, 64'd0, 32'd0, 0);
		play_frame(4'd5);
		wait_drained();
	endtask

	task automatic test_backpressure();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_request       = HOLD_CYCLES;
		compose_frame(4'd6, 1'b1, OP_BIN, 1'b0, LEN_SHORT, 64'd60, 32'd0, 60);
		play_frame(4'd6);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int          counted;
		int          r;
		logic [3:0]  cl;
		logic [3:0]  op;
		logic [63:0] len;
		int          nbytes;
		len_form_t   form;
		cmd_op_t     act;
		logic [7:0]  b;
		logic        have_item;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
				default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
			endcase
			counted = 0;
			while (counted < RANDOM_ITEMS / 4) begin
				cl        = 4'($urandom_range(CLIENTS - 1));
				r         = $urandom_range(99);
				have_item = 1'b1;
				act       = CMD_BYTE;
				b         = 8'($urandom);
				if (r < 2) begin
					frame_len[cl] = 0;
					frame_pos[cl] = 0;
					act = CMD_OPEN;
				end else if (r < 4) begin
					act = CMD_OPEN;
				end else if (frame_pos[cl] < frame_len[cl]) begin
					b = frame_buf[cl][frame_pos[cl]];
					frame_pos[cl]++;
				end else if (ctx_phase[cl] != PH_HDR0) begin
					if ($urandom_range(9) < 6)
						act = CMD_OPEN;
				end else begin
					have_item = 1'b0;
					r = $urandom_range(99);
					if (r < 45)
						op = 4'($urandom_range(2));
					else if (r < 55)
						op = OP_CLOSE;
					else if (r < 67)
						op = OP_PING;
					else if (r < 79)
						op = OP_PONG;
					else
						op = 4'($urandom_range(15));
					r = $urandom_range(99);
					if (r < 65) begin
						form = LEN_SHORT;
						if (r < 4)
							len = 64'($urandom_range(100, 125));
						else if (r < 16)
							len = 64'd0;
						else
							len = 64'($urandom_range(1, 20));
					end else if (r < 88) begin
						form = LEN_EXT16;
						if ($urandom_range(9) == 0)
							len = 64'($urandom_range(41, 300));
						else
							len = 64'($urandom_range(0, 40));
					end else begin
						form = LEN_EXT64;
						len  = 64'($urandom_range(0, 20));
					end
					nbytes = int'(len);
					if (form == LEN_EXT64 && $urandom_range(3) == 0) begin
						len    = {$urandom, $urandom} | (64'd1 << 40);
						nbytes = $urandom_range(1, 20);
					end
					compose_frame(cl, 1'($urandom), op, $urandom_range(3) != 0, form, len,
						$urandom, nbytes);
				end
				if (have_item) begin
					if (act == CMD_OPEN || ctx_phase[cl] != PH_CLOSED)
						counted++;
					send_item(act, cl, b);
				end
			end
			wait_drained();
		end
	endtask

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("result with no item pending: client_out 0x%0h payload_byte 0x%0h",
					client_out, payload_byte);
				failures++;
			end else begin
				want = expected_results.pop_front();
				check_field("client_out", 8'(want.client), 8'(client_out));
				check_field("payload_byte", want.payload, payload_byte);
				check_field("byte_valid", 8'(want.valid), 8'(byte_valid));
				check_field("frame_opcode", 8'(want.opcode), 8'(frame_opcode));
				check_field("frame_fin", 8'(want.fin), 8'(frame_fin));
				check_field("frame_kind", 8'(want.kind), 8'(frame_kind));
				check_field("last_of_frame", 8'(want.last), 8'(last_of_frame));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < CLIENTS; i++) begin
			clear_context(4'(i));
			frame_len[i] = 0;
			frame_pos[i] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		sender_idle_pct    = 24;
		receiver_stall_pct = 24;
		test_masked_text();
		test_ext64_ignored_opcode();
		test_empty_ping();
		test_close_and_reopen();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/wsd_pkg.sv
hdl/wsd_front.sv
hdl/wsd_cmd_queue.sv
hdl/wsd_back.sv
hdl/websocket_frame_deframer_core.sv
hdl/wsd_checker.sv
bench/tb_websocket_frame_deframer_core.sv
